FILE: rtl/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// nrmc_pkg
// Shared types, character codes, field numbers and helper functions for the
// RMC sentence field extractor.
// ----------------------------------------------------------------------------
package nrmc_pkg;

  // Character codes
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  // Header progress
  localparam logic [2:0] HDR_IDLE = 3'd0;
  localparam logic [2:0] HDR_DONE = 3'd6;

  // Field numbers within the sentence
  localparam logic [3:0] FLD_NONE   = 4'd0;
  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_LAT_NS = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_LON_EW = 4'd6;
  localparam logic [3:0] FLD_SPEED  = 4'd7;
  localparam logic [3:0] FLD_COURSE = 4'd8;
  localparam logic [3:0] FLD_DATE   = 4'd9;
  localparam logic [3:0] FLD_LAST   = 4'd15;

  // Accumulator width and ceiling
  localparam int unsigned ACC_W = 30;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // Scales and ceilings of the numeric fields
  localparam logic [13:0] SCALE_ONE     = 14'd1;
  localparam logic [13:0] SCALE_HUNDRED = 14'd100;
  localparam logic [13:0] SCALE_TENK    = 14'd10000;
  localparam logic [29:0] MAX_TIME      = 30'd999999;
  localparam logic [29:0] MAX_LAT       = 30'd99999999;
  localparam logic [29:0] MAX_LON       = 30'd999999999;
  localparam logic [29:0] MAX_SPEED     = 30'd9999999;

  // Open-field accumulators, handed to the commit logic
  typedef struct packed {
    logic [ACC_W-1:0] int_acc;
    logic [ACC_W-1:0] frac_acc;
  } field_acc_t;

  // One result item as held in the output registers
  typedef struct packed {
    logic        sentence_ok;
    logic [19:0] hms_value;
    logic [7:0]  fix_status;
    logic [26:0] lat_scaled;
    logic [7:0]  lat_hemisphere;
    logic [29:0] lon_scaled;
    logic [7:0]  lon_hemisphere;
    logic [23:0] speed_scaled;
    logic [23:0] course_scaled;
    logic [19:0] date_value;
  } rmc_result_t;

  // Expected header character at a given header position
  function automatic logic [7:0] header_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd1:    c = 8'h47;  // G
      3'd2:    c = 8'h50;  // P
      3'd3:    c = 8'h52;  // R
      3'd4:    c = 8'h4D;  // M
      3'd5:    c = 8'h43;  // C
      default: c = CHAR_DOLLAR;
    endcase
    return c;
  endfunction

  function automatic logic is_numeric_field(input logic [3:0] k);
    logic r;
    case (k)
      FLD_TIME, FLD_LAT, FLD_LON, FLD_SPEED, FLD_COURSE, FLD_DATE: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic has_fraction(input logic [3:0] k);
    logic r;
    case (k)
      FLD_LAT, FLD_LON, FLD_SPEED, FLD_COURSE: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // acc*10 + d, saturating at the accumulator ceiling
  function automatic logic [ACC_W-1:0] push_digit(input logic [ACC_W-1:0] acc,
                                                  input logic [3:0] d);
    logic [ACC_W+3:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{ACC_W{1'b0}}, d};
    return (v > {4'b0, ACC_MAX}) ? ACC_MAX : v[ACC_W-1:0];
  endfunction

endpackage

FILE: rtl/nrmc_intf.sv
// ----------------------------------------------------------------------------
// nrmc channel interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface nrmc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface nrmc_result_if;
  logic        valid;
  logic        ready;
  logic        sentence_ok;
  logic [19:0] hms_value;
  logic [7:0]  fix_status;
  logic [26:0] lat_scaled;
  logic [7:0]  lat_hemisphere;
  logic [29:0] lon_scaled;
  logic [7:0]  lon_hemisphere;
  logic [23:0] speed_scaled;
  logic [23:0] course_scaled;
  logic [19:0] date_value;

  modport source (output valid, output sentence_ok, output hms_value, output fix_status,
                  output lat_scaled, output lat_hemisphere, output lon_scaled,
                  output lon_hemisphere, output speed_scaled, output course_scaled,
                  output date_value, input ready);
  modport sink   (input valid, input sentence_ok, input hms_value, input fix_status,
                  input lat_scaled, input lat_hemisphere, input lon_scaled,
                  input lon_hemisphere, input speed_scaled, input course_scaled,
                  input date_value, output ready);
endinterface

FILE: rtl/nrmc_commit.sv
// ----------------------------------------------------------------------------
// nrmc_commit
// Scales the open field's accumulators (int*scale + fraction) and clamps the
// value to the field's range.
// ----------------------------------------------------------------------------
module nrmc_commit
  import nrmc_pkg::*;
(
  input  logic [3:0]  field_num_i,
  input  field_acc_t  acc_i,
  output logic [29:0] value_o
);

  logic [13:0]        scale;
  logic [29:0]        ceiling;
  logic [ACC_W-1:0]   frac_sel;
  logic [43:0]        product;
  logic [44:0]        total;

  // Pick scale and range for the field
  always_comb begin
    case (field_num_i)
      FLD_TIME, FLD_DATE: begin
        scale   = SCALE_ONE;
        ceiling = MAX_TIME;
      end
      FLD_LAT: begin
        scale   = SCALE_TENK;
        ceiling = MAX_LAT;
      end
      FLD_LON: begin
        scale   = SCALE_TENK;
        ceiling = MAX_LON;
      end
      FLD_SPEED, FLD_COURSE: begin
        scale   = SCALE_HUNDRED;
        ceiling = MAX_SPEED;
      end
      default: begin
        scale   = '0;
        ceiling = '0;
      end
    endcase
  end

  // Scale, add fraction, clamp
  assign frac_sel = has_fraction(field_num_i) ? acc_i.frac_acc : '0;
  assign product  = acc_i.int_acc * scale;
  assign total    = {1'b0, product} + {15'b0, frac_sel};
  assign value_o  = (total > {15'b0, ceiling}) ? ceiling : total[29:0];

endmodule

FILE: rtl/nmea_rmc_field_extractor_core.sv
// ----------------------------------------------------------------------------
// nmea_rmc_field_extractor_core
// Parses an RMC sentence from a byte stream and emits its fields on line feed.
// ----------------------------------------------------------------------------
// A line feed's result is registered in the head, or in the skid while it waits.
// Throughput: one byte per cycle; every byte is handled in the cycle it enters,
//   set by the digit accumulate and the field scale-and-clamp multiplier.
// A second result register takes a line feed while one result waits; the input
//   stalls only while both result registers are full.
// Reset: asynchronous, active low; returns the parser to idle, no result held.
module nmea_rmc_field_extractor_core
  import nrmc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  nrmc_byte_if.sink            in_i,
  nrmc_result_if.source        out_o
);

  // Parser state
  logic [2:0]       hdr_pos_q, hdr_pos_d;
  logic             hdr_match_q, hdr_match_d;
  logic [3:0]       field_num_q, field_num_d;
  logic             in_frac_q, in_frac_d;
  logic             stopped_q, stopped_d;
  logic             first_q, first_d;
  field_acc_t       acc_q, acc_d;

  // Held field values
  logic [19:0] utc_q, utc_d;
  logic [7:0]  status_q, status_d;
  logic [26:0] lat_q, lat_d;
  logic [7:0]  lat_ns_q, lat_ns_d;
  logic [29:0] lon_q, lon_d;
  logic [7:0]  lon_ew_q, lon_ew_d;
  logic [23:0] speed_q, speed_d;
  logic [23:0] course_q, course_d;
  logic [19:0] date_q, date_d;

  // Held values with the open field committed
  logic [19:0] cur_utc;
  logic [26:0] cur_lat;
  logic [29:0] cur_lon;
  logic [23:0] cur_speed;
  logic [23:0] cur_course;
  logic [19:0] cur_date;

  // Result registers: head drives the channel, skid catches one more item
  rmc_result_t res_d;
  rmc_result_t out_q;
  rmc_result_t skid_q;
  logic        out_valid_q;
  logic        skid_valid_q;
  logic        out_take;

  logic        in_fire;
  logic        emit;
  logic        ok;
  logic [7:0]  b;
  logic [29:0] commit_val;

  assign in_i.ready = !skid_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign b          = in_i.byte_in;
  assign emit       = in_fire && (b == CHAR_LF);
  assign ok         = hdr_match_q && (hdr_pos_q == HDR_DONE);
  assign out_take   = out_valid_q && out_o.ready;

  nrmc_commit u_commit (
    .field_num_i (field_num_q),
    .acc_i       (acc_q),
    .value_o     (commit_val)
  );

  // Overlay the committed open field on the held values
  always_comb begin
    cur_utc    = (field_num_q == FLD_TIME)   ? commit_val[19:0] : utc_q;
    cur_lat    = (field_num_q == FLD_LAT)    ? commit_val[26:0] : lat_q;
    cur_lon    = (field_num_q == FLD_LON)    ? commit_val       : lon_q;
    cur_speed  = (field_num_q == FLD_SPEED)  ? commit_val[23:0] : speed_q;
    cur_course = (field_num_q == FLD_COURSE) ? commit_val[23:0] : course_q;
    cur_date   = (field_num_q == FLD_DATE)   ? commit_val[19:0] : date_q;
  end

  // Next parser state for the accepted byte
  always_comb begin
    hdr_pos_d   = hdr_pos_q;
    hdr_match_d = hdr_match_q;
    field_num_d = field_num_q;
    in_frac_d   = in_frac_q;
    stopped_d   = stopped_q;
    first_d     = first_q;
    acc_d       = acc_q;
    utc_d       = utc_q;
    status_d    = status_q;
    lat_d       = lat_q;
    lat_ns_d    = lat_ns_q;
    lon_d       = lon_q;
    lon_ew_d    = lon_ew_q;
    speed_d     = speed_q;
    course_d    = course_q;
    date_d      = date_q;

    if (in_fire) begin
      if ((b == CHAR_LF) || (b == CHAR_DOLLAR)) begin
        // Drop everything; a dollar opens a new header
        hdr_pos_d   = (b == CHAR_DOLLAR) ? 3'd1 : HDR_IDLE;
        hdr_match_d = (b == CHAR_DOLLAR);
        field_num_d = FLD_NONE;
        in_frac_d   = 1'b0;
        stopped_d   = 1'b0;
        first_d     = 1'b1;
        acc_d       = '0;
        utc_d       = '0;
        status_d    = '0;
        lat_d       = '0;
        lat_ns_d    = '0;
        lon_d       = '0;
        lon_ew_d    = '0;
        speed_d     = '0;
        course_d    = '0;
        date_d      = '0;
      end else if (hdr_pos_q == HDR_IDLE) begin
        // Ignore bytes outside a sentence
      end else if (hdr_pos_q < HDR_DONE) begin
        // Compare header bytes
        if (b != header_char(hdr_pos_q)) hdr_match_d = 1'b0;
        hdr_pos_d = hdr_pos_q + 3'd1;
      end else if (b == CHAR_COMMA) begin
        // Commit the open field and advance
        utc_d       = cur_utc;
        lat_d       = cur_lat;
        lon_d       = cur_lon;
        speed_d     = cur_speed;
        course_d    = cur_course;
        date_d      = cur_date;
        field_num_d = (field_num_q == FLD_LAST) ? FLD_LAST : field_num_q + 4'd1;
        in_frac_d   = 1'b0;
        stopped_d   = 1'b0;
        first_d     = 1'b1;
        acc_d       = '0;
      end else if (is_numeric_field(field_num_q)) begin
        // Accumulate digits until the first non-digit other than a fraction's point
        first_d = 1'b0;
        if (!stopped_q) begin
          if ((b >= CHAR_ZERO) && (b <= CHAR_NINE)) begin
            if (in_frac_q) acc_d.frac_acc = push_digit(acc_q.frac_acc, b[3:0]);
            else           acc_d.int_acc  = push_digit(acc_q.int_acc, b[3:0]);
          end else if ((b == CHAR_DOT) && !in_frac_q && has_fraction(field_num_q)) begin
            in_frac_d = 1'b1;
          end else begin
            stopped_d = 1'b1;
          end
        end
      end else if ((field_num_q == FLD_STATUS) || (field_num_q == FLD_LAT_NS) ||
                   (field_num_q == FLD_LON_EW)) begin
        // Keep the first byte of a character field
        first_d = 1'b0;
        if (first_q) begin
          case (field_num_q)
            FLD_STATUS: status_d = b;
            FLD_LAT_NS: lat_ns_d = b;
            default:    lon_ew_d = b;
          endcase
        end
      end
    end
  end

  // Parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q   <= HDR_IDLE;
      hdr_match_q <= 1'b0;
      field_num_q <= FLD_NONE;
      in_frac_q   <= 1'b0;
      stopped_q   <= 1'b0;
      first_q     <= 1'b1;
      acc_q       <= '0;
      utc_q       <= '0;
      status_q    <= '0;
      lat_q       <= '0;
      lat_ns_q    <= '0;
      lon_q       <= '0;
      lon_ew_q    <= '0;
      speed_q     <= '0;
      course_q    <= '0;
      date_q      <= '0;
    end else begin
      hdr_pos_q   <= hdr_pos_d;
      hdr_match_q <= hdr_match_d;
      field_num_q <= field_num_d;
      in_frac_q   <= in_frac_d;
      stopped_q   <= stopped_d;
      first_q     <= first_d;
      acc_q       <= acc_d;
      utc_q       <= utc_d;
      status_q    <= status_d;
      lat_q       <= lat_d;
      lat_ns_q    <= lat_ns_d;
      lon_q       <= lon_d;
      lon_ew_q    <= lon_ew_d;
      speed_q     <= speed_d;
      course_q    <= course_d;
      date_q      <= date_d;
    end
  end

  // Build the result item, zeroed when the header failed
  always_comb begin
    res_d             = '0;
    res_d.sentence_ok = ok;
    if (ok) begin
      res_d.hms_value      = cur_utc;
      res_d.fix_status     = status_q;
      res_d.lat_scaled     = cur_lat;
      res_d.lat_hemisphere = lat_ns_q;
      res_d.lon_scaled     = cur_lon;
      res_d.lon_hemisphere = lon_ew_q;
      res_d.speed_scaled   = cur_speed;
      res_d.course_scaled  = cur_course;
      res_d.date_value     = cur_date;
    end
  end

  // Result valid flags: load head or skid on line feed, refill head from skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (emit) begin
      if (out_valid_q && !out_o.ready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: hold while waiting, advance skid into head once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q  <= '0;
      skid_q <= '0;
    end else if (emit) begin
      if (out_valid_q && !out_o.ready) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end else if (out_take && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.sentence_ok    = out_q.sentence_ok;
  assign out_o.hms_value      = out_q.hms_value;
  assign out_o.fix_status     = out_q.fix_status;
  assign out_o.lat_scaled     = out_q.lat_scaled;
  assign out_o.lat_hemisphere = out_q.lat_hemisphere;
  assign out_o.lon_scaled     = out_q.lon_scaled;
  assign out_o.lon_hemisphere = out_q.lon_hemisphere;
  assign out_o.speed_scaled   = out_q.speed_scaled;
  assign out_o.course_scaled  = out_q.course_scaled;
  assign out_o.date_value     = out_q.date_value;

  // Checks
  a_lf_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("line feed did not produce a result item");

  a_lf_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (hdr_pos_q == HDR_IDLE) && (field_num_q == FLD_NONE))
    else $error("parser not idle after line feed");

  a_fields_after_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (field_num_q != FLD_NONE) |-> (hdr_pos_q == HDR_DONE))
    else $error("field stepping before header complete");

  a_bad_sentence_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.sentence_ok) |->
      (out_o.hms_value == '0) && (out_o.lat_scaled == '0) && (out_o.lon_scaled == '0) &&
      (out_o.date_value == '0) && (out_o.fix_status == '0))
    else $error("rejected sentence carries field data");

  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result item with the head empty");

endmodule

FILE: tb/nrmc_fix_checker.sv
// ----------------------------------------------------------------------------
// nrmc_fix_checker
// Watches the byte and result channels of the RMC field extractor. Runs its
// own parser over every accepted byte, queues the fix that each line feed
// must produce, and compares every accepted result item field by field.
// ----------------------------------------------------------------------------
module nrmc_fix_checker
  import nrmc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  nrmc_byte_if          byte_mon_i,
  nrmc_result_if        fix_mon_i,
  output int            fail_count_o,
  output int            pending_o
);

  // "$GPRMC", first character in the top byte
  localparam logic [47:0] RMC_TAG = {CHAR_DOLLAR, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

  typedef struct packed {
    logic        sentence_ok;
    logic [19:0] hms_value;
    logic [7:0]  fix_status;
    logic [26:0] lat_scaled;
    logic [7:0]  lat_hemisphere;
    logic [29:0] lon_scaled;
    logic [7:0]  lon_hemisphere;
    logic [23:0] speed_scaled;
    logic [23:0] course_scaled;
    logic [19:0] date_value;
  } rmc_fix_t;

  rmc_fix_t expected_fix_q[$];

  // Parser state
  logic [2:0]       hdr_pos;
  logic             hdr_ok;
  logic [3:0]       fld;
  logic             frac_mode;
  logic             digits_done;
  logic             first_byte;
  logic [ACC_W-1:0] int_acc;
  logic [ACC_W-1:0] frac_acc;
  logic [31:0]      held_val [1:9];

  // Weight of the integer part; 0 marks a character field or no field
  function automatic longint unsigned fld_scale(input logic [3:0] k);
    case (k)
      FLD_TIME, FLD_DATE:     return 1;
      FLD_LAT, FLD_LON:       return 10000;
      FLD_SPEED, FLD_COURSE:  return 100;
      default:                return 0;
    endcase
  endfunction

  function automatic longint unsigned fld_ceiling(input logic [3:0] k);
    case (k)
      FLD_TIME, FLD_DATE:     return MAX_TIME;
      FLD_LAT:                return MAX_LAT;
      FLD_LON:                return MAX_LON;
      default:                return MAX_SPEED;
    endcase
  endfunction

  function automatic logic [ACC_W-1:0] add_decimal(input logic [ACC_W-1:0] acc,
                                                   input logic [7:0] c);
    longint unsigned v;
    v = 64'(acc) * 10 + 64'(c) - 64'(CHAR_ZERO);
    if (v > 64'(ACC_MAX)) v = 64'(ACC_MAX);
    return v[ACC_W-1:0];
  endfunction

  task automatic open_field();
    frac_mode   = 1'b0;
    digits_done = 1'b0;
    first_byte  = 1'b1;
    int_acc     = '0;
    frac_acc    = '0;
  endtask

  task automatic clear_parser();
    hdr_pos = HDR_IDLE;
    hdr_ok  = 1'b0;
    fld     = FLD_NONE;
    open_field();
    for (int i = 1; i <= 9; i++) held_val[i] = '0;
  endtask

  // Scale, clamp and hold the value of the open numeric field
  task automatic commit_field();
    longint unsigned scale;
    longint unsigned v;
    scale = fld_scale(fld);
    if (scale == 0) return;
    if (scale == 1) v = 64'(int_acc);
    else            v = 64'(int_acc) * scale + 64'(frac_acc);
    if (v > fld_ceiling(fld)) v = fld_ceiling(fld);
    held_val[fld] = v[31:0];
  endtask

  task automatic take_field_byte(input logic [7:0] b);
    longint unsigned scale;
    scale = fld_scale(fld);
    if (fld < FLD_TIME || fld > FLD_DATE) return;
    // Character field: keep the first byte only
    if (scale == 0) begin
      if (first_byte) held_val[fld] = 32'(b);
      first_byte = 1'b0;
      return;
    end
    first_byte = 1'b0;
    if (digits_done) return;
    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      if (frac_mode) frac_acc = add_decimal(frac_acc, b);
      else           int_acc  = add_decimal(int_acc, b);
    end else if (b == CHAR_DOT && !frac_mode && scale > 1) begin
      frac_mode = 1'b1;
    end else begin
      digits_done = 1'b1;
    end
  endtask

  // Advance the parser by one accepted byte; a line feed queues a fix
  task automatic parse_rmc_byte(input logic [7:0] b);
    rmc_fix_t fix;
    logic     ok;
    if (b == CHAR_LF) begin
      ok = hdr_ok && (hdr_pos == HDR_DONE);
      commit_field();
      fix.sentence_ok    = ok;
      fix.hms_value      = ok ? held_val[FLD_TIME][19:0]   : '0;
      fix.fix_status     = ok ? held_val[FLD_STATUS][7:0]  : '0;
      fix.lat_scaled     = ok ? held_val[FLD_LAT][26:0]    : '0;
      fix.lat_hemisphere = ok ? held_val[FLD_LAT_NS][7:0]  : '0;
      fix.lon_scaled     = ok ? held_val[FLD_LON][29:0]    : '0;
      fix.lon_hemisphere = ok ? held_val[FLD_LON_EW][7:0]  : '0;
      fix.speed_scaled   = ok ? held_val[FLD_SPEED][23:0]  : '0;
      fix.course_scaled  = ok ? held_val[FLD_COURSE][23:0] : '0;
      fix.date_value     = ok ? held_val[FLD_DATE][19:0]   : '0;
      expected_fix_q.push_back(fix);
      clear_parser();
    end else if (b == CHAR_DOLLAR) begin
      clear_parser();
      hdr_pos = 3'd1;
      hdr_ok  = 1'b1;
    end else if (hdr_pos != HDR_IDLE) begin
      if (hdr_pos < HDR_DONE) begin
        if (b != RMC_TAG[8 * (5 - int'(hdr_pos)) +: 8]) hdr_ok = 1'b0;
        hdr_pos = hdr_pos + 3'd1;
      end else if (b == CHAR_COMMA) begin
        commit_field();
        if (fld != FLD_LAST) fld = fld + 4'd1;
        open_field();
      end else begin
        take_field_byte(b);
      end
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic compare_fix();
    rmc_fix_t want;
    if (expected_fix_q.size() == 0) begin
      $error("result item with no line feed waiting for it");
      fail_count_o++;
      return;
    end
    want = expected_fix_q.pop_front();
    check_field("sentence_ok",    want.sentence_ok,    fix_mon_i.sentence_ok);
    check_field("hms_value",      want.hms_value,      fix_mon_i.hms_value);
    check_field("fix_status",     want.fix_status,     fix_mon_i.fix_status);
    check_field("lat_scaled",     want.lat_scaled,     fix_mon_i.lat_scaled);
    check_field("lat_hemisphere", want.lat_hemisphere, fix_mon_i.lat_hemisphere);
    check_field("lon_scaled",     want.lon_scaled,     fix_mon_i.lon_scaled);
    check_field("lon_hemisphere", want.lon_hemisphere, fix_mon_i.lon_hemisphere);
    check_field("speed_scaled",   want.speed_scaled,   fix_mon_i.speed_scaled);
    check_field("course_scaled",  want.course_scaled,  fix_mon_i.course_scaled);
    check_field("date_value",     want.date_value,     fix_mon_i.date_value);
  endtask

  // Sample both channels at the edge: results first, then the new byte
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_parser();
      expected_fix_q.delete();
      fail_count_o = 0;
    end else begin
      if (fix_mon_i.valid && fix_mon_i.ready) compare_fix();
      if (byte_mon_i.valid && byte_mon_i.ready) parse_rmc_byte(byte_mon_i.byte_in);
    end
    pending_o = expected_fix_q.size();
  end

endmodule

FILE: tb/tb_nmea_rmc_field_extractor_core.sv
// ----------------------------------------------------------------------------
// tb_nmea_rmc_field_extractor_core
// Feeds the RMC field extractor with directed sentences and then with random
// well-formed, broken and noise lines, with random gaps on the byte side and
// random stalls on the result side. The checker beside the block predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_nmea_rmc_field_extractor_core;
  import nrmc_pkg::*;

  localparam int RANDOM_BYTES = 950;
  localparam int MIN_LINES    = 10;
  localparam int LONG_HOLD    = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 4;

  logic clk_i;
  logic rst_ni;

  nrmc_byte_if   byte_ch ();
  nrmc_result_if fix_ch ();

  int         fail_count;
  int         pending_fixes;
  int         bytes_sent;
  int         lines_sent;
  bit         steady_feed;
  bit         long_hold_req;
  logic [7:0] line_q[$];

  nmea_rmc_field_extractor_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (fix_ch)
  );

  nrmc_fix_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_mon_i   (byte_ch),
    .fix_mon_i    (fix_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_fixes)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_letter(input string choices);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'($urandom_range(128, 255));
    return choices[$urandom_range(0, choices.len() - 1)];
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    repeat (n) line_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
  endtask

  // Integer digits, maybe a fraction, rarely a stray byte or a long run
  task automatic add_numeric(input int usual_max);
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 13) : $urandom_range(0, usual_max);
    add_digits(n);
    if ($urandom_range(0, 2) != 0) begin
      line_q.push_back(CHAR_DOT);
      add_digits(($urandom_range(0, 19) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5));
    end
    if ($urandom_range(0, 9) == 0) begin
      line_q.push_back(pick_letter("A.x-/ 9"));
      add_digits($urandom_range(0, 3));
    end
  endtask

  task automatic add_letter_field(input string choices);
    if ($urandom_range(0, 6) != 0) line_q.push_back(pick_letter(choices));
  endtask

  // Well-formed sentence with random content
  task automatic add_rmc_sentence();
    string hexd;
    int    extra;
    hexd = "0123456789ABCDEF";
    add_text("$GPRMC");
    if ($urandom_range(0, 19) == 0) add_text("X");
    add_text(",");  add_numeric(6);
    add_text(",");  add_letter_field("AAV");
    add_text(",");  add_numeric(4);
    add_text(",");  add_letter_field("NS");
    add_text(",");  add_numeric(5);
    add_text(",");  add_letter_field("EW");
    add_text(",");  add_numeric(3);
    add_text(",");  add_numeric(3);
    add_text(",");  add_numeric(6);
    extra = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 7) : 0;
    repeat (extra) begin
      line_q.push_back(CHAR_COMMA);
      if ($urandom_range(0, 1) != 0) add_numeric(3);
    end
    if ($urandom_range(0, 1) != 0) begin
      add_text("*");
      line_q.push_back(hexd[$urandom_range(0, 15)]);
      line_q.push_back(hexd[$urandom_range(0, 15)]);
    end
    if ($urandom_range(0, 1) != 0) add_text("\r");
    line_q.push_back(CHAR_LF);
  endtask

  // Damage a built sentence: bad header, stray byte, cut short or restarted
  task automatic break_line();
    int cut;
    case ($urandom_range(0, 3))
      0: line_q[$urandom_range(1, 5)] = 8'($urandom_range(65, 90));
      1: line_q[$urandom_range(0, line_q.size() - 2)] = 8'($urandom_range(0, 255));
      2: begin
        cut = $urandom_range(1, line_q.size() - 2);
        while (line_q.size() > cut) void'(line_q.pop_back());
        line_q.push_back(CHAR_LF);
      end
      default: line_q[$urandom_range(7, line_q.size() - 2)] = CHAR_DOLLAR;
    endcase
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1) != 0) line_q.push_back(CHAR_LF);
  endtask

  // Offer one byte and hold it until the block takes it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = steady_feed ? 0 : pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.byte_in <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    bytes_sent++;
    if (b == CHAR_LF) lines_sent++;
  endtask

  task automatic send_line();
    steady_feed = ($urandom_range(0, 3) == 0);
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  task automatic run_line(input string s);
    add_text(s);
    send_line();
  endtask

  // Hold the sender until every queued fix has come out
  task automatic pause_for_results();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_fixes == 0);
    @(posedge clk_i);
  endtask

  // Reset, directed lines, random lines, drain and verdict
  initial begin
    int n_line;
    int r;
    rst_ni          <= 1'b0;
    byte_ch.valid   <= 1'b0;
    byte_ch.byte_in <= 8'h00;
    long_hold_req   = 1'b0;
    bytes_sent      = 0;
    lines_sent      = 0;
    n_line          = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle bytes, a full sentence, header faults, empty fields,
    // saturation, fraction with no integer, restart and stopped digits
    run_line("\n");
    run_line("ab\n");
    run_line("$GPRMC,123519.00,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n");
    run_line("$GPRMB,1,A\n");
    run_line("$G,PRMC,5\n");
    run_line("$GPRMCxy,7,V\n");
    run_line("$GPRMC,,,,,,,,,\n");
    run_line("$GPRMC,99999999999,A,.5,S,0.0001,W,99999999999.99,.25,12345678901\n");
    run_line("$GPR$GPRMC,42\n");
    run_line("$GPRMC,12a34,AB,12.3.4,N,7,\n");
    run_line("$GPRM\n");
    add_text("$GPRMC,");
    line_q.push_back(8'h00);
    line_q.push_back(CHAR_COMMA);
    line_q.push_back(8'hFF);
    add_text(",1.99999999999\n");
    send_line();
    pause_for_results();

    // Random lines: mostly good sentences, some damaged, some noise
    bytes_sent = 0;
    lines_sent = 0;
    while (bytes_sent < RANDOM_BYTES || lines_sent < MIN_LINES) begin
      n_line++;
      r = $urandom_range(0, 99);
      if (r < 75) begin
        add_rmc_sentence();
      end else if (r < 90) begin
        add_rmc_sentence();
        break_line();
      end else begin
        add_noise();
      end
      send_line();
      if (n_line == 3) long_hold_req = 1'b1;
      if (n_line % 15 == 0) pause_for_results();
    end

    // Drain and give the verdict
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_fixes == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("nmea_rmc_field_extractor_core regression: pass");
    end else begin
      $display("nmea_rmc_field_extractor_core regression: fail");
    end
    $finish;
  end

  // Result side: random stalls, free-running stretches, one long hold-off
  initial begin
    int stall;
    int run;
    fix_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        fix_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      stall = pick_gap();
      if (stall > 0) begin
        fix_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(40, 150);
      fix_ch.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if ((byte_ch.valid && byte_ch.ready) || (fix_ch.valid && fix_ch.ready))
          idle_cycles = 0;
        else
          idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("nmea_rmc_field_extractor_core regression: fail");
          $finish;
        end
      end
    end
  end

endmodule
